FILE: sv/eq_pkg.sv
// shared types, constants and request codes for the coalescing event queue
// no dependencies
package eq_pkg;

    localparam int DEFAULT_DEPTH    = 64;
    localparam int DEFAULT_CAPACITY = 50;
    localparam int MIN_CAPACITY     = 10;
    localparam int CFG_INDEX_W      = 3;

    typedef enum logic [2:0] {
        REQ_POST   = 3'd0,
        REQ_SEND   = 3'd1,
        REQ_GET    = 3'd2,
        REQ_PEEK   = 3'd3,
        REQ_STATUS = 3'd4
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_QUIT  = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        CFG_CAPACITY    = 3'd0,
        CFG_PAINT       = 3'd1,
        CFG_MOUSEMOVE   = 3'd2,
        CFG_QUIT        = 3'd3,
        CFG_KEYBOARD    = 3'd4,
        CFG_TIMER       = 3'd5,
        CFG_MOUSE_FIRST = 3'd6,
        CFG_MOUSE_LAST  = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,      // read entry at scan index (get, peek, status, compaction outer)
        S_SCAN_WAIT,
        S_INNER,     // compaction inner paint sweep
        S_INNER_WAIT,
        S_MOVE,      // mouse-move run check
        S_MOVE_WAIT,
        S_SHIFT,     // remove_at: shift entries down
        S_SHIFT_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] window_id;
        logic [15:0] msg_code;
        logic [31:0] param_one;
        logic [31:0] param_two;
        logic [15:0] range_first;
        logic [15:0] range_last;
        logic        remove_flag;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_window;
        logic [15:0] out_code;
        logic [31:0] out_param_one;
        logic [31:0] out_param_two;
        logic        out_is_send;
        logic [6:0]  class_flags;
    } result_t;

    // one stored entry: send mark, code, window, two params
    typedef struct packed {
        logic        is_send;
        logic [15:0] code;
        logic [15:0] window;
        logic [31:0] p1;
        logic [31:0] p2;
    } entry_t;

endpackage

FILE: sv/event_queue_with_coalescing.sv
// top level of the coalescing event queue: sequencer, config registers
// depends on eq_pkg and eq_store
//
//  channel   | signals                          | transfer
//  ----------+----------------------------------+----------------------------------
//  request   | start, busy, req                 | taken when start & !busy
//  result    | done, res                        | one cycle strobe, cannot stall
//  config    | cfg_valid, cfg_ready, cfg_index, | written when cfg_valid & cfg_ready
//            | cfg_data                         |
//
// searches and shifts walk the entry memory through one read port and one
// comparator set; each entry read takes an address state and a registered-data state
// post/send: accept, then result strobe; a post that fills the queue runs
// compaction over the stored entries before its result strobe
// get: read the head, then shift down; peek/status: scan (peek shifts on remove)
// reset clears the entry count and code config and restores the default capacity;
// memory contents need no clearing; busy is high from acceptance until the cycle after done
module event_queue_with_coalescing
    import eq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               req,
    output logic                   done,
    output result_t                res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    // configuration registers
    logic [6:0]  cap_cfg_reg;
    logic [15:0] code_cfg_reg [1:7];

    // capacity as the queue sees it: small values pick the default, big ones clip
    logic [CW-1:0] cap_eff;
    always_comb
    begin
        if (cap_cfg_reg <= 7'(MIN_CAPACITY))
            cap_eff = CW'(DEFAULT_CAPACITY > QUEUE_DEPTH ? QUEUE_DEPTH : DEFAULT_CAPACITY);
        else if (32'(cap_cfg_reg) > 32'(QUEUE_DEPTH))
            cap_eff = CW'(QUEUE_DEPTH);
        else
            cap_eff = CW'(cap_cfg_reg);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= 7'(DEFAULT_CAPACITY);
            for (int i = 1; i < 8; i++)
            begin
                code_cfg_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_CAPACITY)
                cap_cfg_reg <= cfg_data[6:0];
            else
                code_cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // sequencer state
    state_t        state_reg, state_next;
    request_t      req_reg, req_next;
    result_t       res_reg, res_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] b_reg, b_next;        // outer scan index
    logic [CW-1:0] i_reg, i_next;        // inner / shift index
    logic [CW-1:0] base_reg, base_next;  // return point of the inner sweep
    entry_t        ref_reg, ref_next;    // entry at the outer index
    logic          compact_reg, compact_next;
    logic [1:0]    ret_reg, ret_next;    // where to go after a shift

    localparam logic [1:0] RET_DONE  = 2'd0;
    localparam logic [1:0] RET_INNER = 2'd1;
    localparam logic [1:0] RET_MOVE  = 2'd2;

    // memory port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    eq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [15:0] paint_c, move_c, quit_c, kbd_c, tmr_c, mf_c, ml_c;
    assign paint_c = code_cfg_reg[CFG_PAINT];
    assign move_c  = code_cfg_reg[CFG_MOUSEMOVE];
    assign quit_c  = code_cfg_reg[CFG_QUIT];
    assign kbd_c   = code_cfg_reg[CFG_KEYBOARD];
    assign tmr_c   = code_cfg_reg[CFG_TIMER];
    assign mf_c    = code_cfg_reg[CFG_MOUSE_FIRST];
    assign ml_c    = code_cfg_reg[CFG_MOUSE_LAST];

    logic peek_hit;
    assign peek_hit = !rd_data.is_send
                   && (req_reg.window_id == 16'd0 || req_reg.window_id == rd_data.window)
                   && ((req_reg.range_first == 16'd0 && req_reg.range_last == 16'd0)
                       || (req_reg.range_first <= rd_data.code
                           && req_reg.range_last >= rd_data.code));

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        count_next   = count_reg;
        b_next       = b_reg;
        i_next       = i_reg;
        base_next    = base_reg;
        ref_next     = ref_reg;
        compact_next = compact_reg;
        ret_next     = ret_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        wr_data      = rd_data;
        rd_addr      = AW'(b_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = req;
                    res_next     = '0;
                    b_next       = '0;
                    compact_next = 1'b0;
                    unique case (req.req_type)
                        REQ_POST, REQ_SEND:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(count_reg);
                                wr_data = '{is_send: req.req_type == REQ_SEND,
                                            code: req.msg_code, window: req.window_id,
                                            p1: req.param_one, p2: req.param_two};
                                count_next = count_reg + 1'b1;
                                if (req.req_type == REQ_POST && count_reg + 1'b1 == cap_eff)
                                begin
                                    compact_next = 1'b1;
                                    state_next   = S_SCAN;
                                end
                                else
                                    state_next = S_DONE;
                            end
                        end
                        REQ_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        REQ_PEEK:
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_SCAN;
                        end
                        REQ_STATUS:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                rd_addr = AW'(b_reg);
                if (b_reg >= count_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SCAN_WAIT;
            end

            S_SCAN_WAIT:
            begin
                ref_next = rd_data;
                if (compact_reg)
                begin
                    if (rd_data.code == paint_c)
                    begin
                        i_next     = b_reg + 1'b1;
                        state_next = S_INNER;
                    end
                    else
                    begin
                        i_next     = b_reg + 1'b1;
                        state_next = S_MOVE;
                    end
                end
                else
                begin
                    unique case (req_reg.req_type)
                        REQ_GET:
                        begin
                            res_next.status = (rd_data.code == quit_c) ? ST_QUIT : ST_OK;
                            res_next.out_window    = rd_data.window;
                            res_next.out_code      = rd_data.code;
                            res_next.out_param_one = rd_data.p1;
                            res_next.out_param_two = rd_data.p2;
                            res_next.out_is_send   = rd_data.is_send;
                            base_next  = '0;
                            i_next     = '0;
                            ret_next   = RET_DONE;
                            state_next = S_SHIFT;
                        end
                        REQ_PEEK:
                        begin
                            if (peek_hit)
                            begin
                                res_next.status        = ST_OK;
                                res_next.out_window    = rd_data.window;
                                res_next.out_code      = rd_data.code;
                                res_next.out_param_one = rd_data.p1;
                                res_next.out_param_two = rd_data.p2;
                                res_next.out_is_send   = 1'b0;
                                if (req_reg.remove_flag)
                                begin
                                    i_next     = b_reg;
                                    ret_next   = RET_DONE;
                                    state_next = S_SHIFT;
                                end
                                else
                                    state_next = S_DONE;
                            end
                            else
                            begin
                                b_next     = b_reg + 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // status query: classify and accumulate
                            res_next.class_flags[rd_data.is_send ? 1 : 0] = 1'b1;
                            if (rd_data.code == kbd_c)
                            begin
                                res_next.class_flags[2] = 1'b1;
                                res_next.class_flags[3] = 1'b1;
                            end
                            else if (rd_data.code >= mf_c && rd_data.code <= ml_c)
                            begin
                                res_next.class_flags[4] = 1'b1;
                                res_next.class_flags[3] = 1'b1;
                            end
                            else if (rd_data.code == tmr_c)
                                res_next.class_flags[5] = 1'b1;
                            else if (rd_data.code == paint_c)
                                res_next.class_flags[6] = 1'b1;
                            b_next     = b_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            // paint sweep: drop later posted paints to the same window
            S_INNER:
            begin
                rd_addr = AW'(i_reg);
                if (i_reg >= count_reg)
                begin
                    i_next     = b_reg + 1'b1;
                    state_next = S_MOVE;
                end
                else
                    state_next = S_INNER_WAIT;
            end

            S_INNER_WAIT:
            begin
                if (rd_data.code == paint_c && rd_data.window == ref_reg.window
                    && !rd_data.is_send)
                begin
                    base_next  = i_reg;
                    ret_next   = RET_INNER;
                    state_next = S_SHIFT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_INNER;
                end
            end

            // mouse-move run: look at b+1, remove b when it matches
            S_MOVE:
            begin
                rd_addr = AW'(b_reg + 1'b1);
                if (ref_reg.code == move_c && !ref_reg.is_send
                    && b_reg + 1'b1 < count_reg)
                    state_next = S_MOVE_WAIT;
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end

            S_MOVE_WAIT:
            begin
                if (rd_data.code == move_c && rd_data.window == ref_reg.window
                    && rd_data.p2 == ref_reg.p2 && !rd_data.is_send)
                begin
                    ref_next   = rd_data;
                    i_next     = b_reg;
                    ret_next   = RET_MOVE;
                    state_next = S_SHIFT;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end

            // remove entry at i: copy i+1 down to i, walking to the tail
            S_SHIFT:
            begin
                rd_addr = AW'(i_reg + 1'b1);
                if (i_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    unique case (ret_reg)
                        RET_INNER:
                        begin
                            i_next     = base_reg;
                            state_next = S_INNER;
                        end
                        RET_MOVE:
                        begin
                            state_next = S_MOVE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else
                    state_next = S_SHIFT_WAIT;
            end

            S_SHIFT_WAIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(i_reg);
                wr_data    = rd_data;
                i_next     = i_reg + 1'b1;
                state_next = S_SHIFT;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // inner sweep resumes at the removed slot
        if (state_reg == S_INNER_WAIT && state_next == S_SHIFT)
            i_next = i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            compact_reg <= 1'b0;
            ret_reg     <= RET_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            compact_reg <= compact_next;
            ret_reg     <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        b_reg    <= b_next;
        i_reg    <= i_next;
        base_reg <= base_next;
        ref_reg  <= ref_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = done ? res_reg : '0;

endmodule

FILE: sv/eq_store.sv
// entry memory of the event queue: one write port, one registered read port
// depends on eq_pkg
module eq_store
    import eq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/eq_checker.sv
// port-level checks for the coalescing event queue, bound to the top level
// depends on eq_pkg
module eq_checker
    import eq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t res
);

    // a request taken makes the block busy next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted request");

    // the strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a result ends the busy period
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("still busy after result");

    // strobe only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result outside a request");

    // full rejection carries no entry
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.status == ST_FULL) |-> (res.out_code == '0 && res.class_flags == '0))
        else $error("full status with payload");

endmodule

bind event_queue_with_coalescing eq_checker u_eq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);
